// ===== src/bitmap_block_allocator_core_assert.svh =====
// assertion macros for the bitmap block allocator
// expects clk and rst_n in the scope of use
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bba_pkg.sv =====
// shared types and constants for the bitmap block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS_DEF  = 32;
  localparam int BLOCK_BYTES_DEF = 128;

  localparam int CMD_W    = 2;
  localparam int LEN_W    = 6;
  localparam int IDX_W    = 6;
  localparam int GRANT_W  = 5;
  localparam int OFFSET_W = 12;
  localparam int USED_W   = 6;
  localparam int MAP_W    = 32;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADLEN = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== src/bba_req_if.sv =====
// request channel of the bitmap block allocator
// depends on bba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if;
  import bba_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [LEN_W-1:0] run_length;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output cmd, output run_length, output block_index,
                  input ready);
  modport sink (input valid, input cmd, input run_length, input block_index,
                output ready);
endinterface

`default_nettype wire

// ===== src/bba_rsp_if.sv =====
// result channel of the bitmap block allocator
// depends on bba_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bba_rsp_if;
  import bba_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [GRANT_W-1:0]  granted_index;
  logic [OFFSET_W-1:0] byte_offset;
  logic [USED_W-1:0]   used_blocks;
  logic [MAP_W-1:0]    occupancy_map;

  modport source (output valid, output status, output granted_index, output byte_offset,
                  output used_blocks, output occupancy_map, input ready);
  modport sink (input valid, input status, input granted_index, input byte_offset,
                input used_blocks, input occupancy_map, output ready);
endinterface

`default_nettype wire

// ===== src/bitmap_block_allocator_core.sv =====
// bitmap block allocator, first fit, over a pool of NUM_BLOCKS blocks
// depends on bba_pkg, bba_req_if, bba_rsp_if and the assertion macro header
//
// usage:
//   in_req  carries one request: cmd (allocate one, allocate run, free),
//           run_length and block_index; taken when valid and ready are high
//   out_rsp carries one result per request: status, granted index, byte
//           offset, allocated block count and the occupancy map after it
// timing:
//   a free, a bad run length or an unknown command goes from idle straight to
//   the done state; an allocation scans start positions one per cycle with
//   a single masked compare, then goes to the done state on a grant or
//   once the last start position fails; the done state loads the result
//   into the output register and ready returns in the same cycle, so a new
//   request is not taken until the last one has its result loaded
// reset:
//   every block free, count zero, no result pending
// back-pressure:
//   the result sits in an output register; a new request may be taken while
//   it waits, but that request's result holds until the output is taken
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  bba_req_if.sink   in_req,
  bba_rsp_if.source out_rsp
);
  import bba_pkg::*;

  localparam int IW   = $clog2(NUM_BLOCKS);
  localparam int UW   = $clog2(NUM_BLOCKS + 1);
  localparam int BB_W = $clog2(BLOCK_BYTES + 1);
  localparam int CW   = LEN_W + 1;
  localparam logic [CW-1:0]   NB_CMP = CW'(NUM_BLOCKS);
  localparam logic [BB_W-1:0] BB_L   = BB_W'(BLOCK_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                 state_r, state_nxt;
  logic [NUM_BLOCKS-1:0]  occ_r, occ_nxt;
  logic [UW-1:0]          used_r, used_nxt;
  logic [NUM_BLOCKS-1:0]  mask_r, mask_nxt;
  logic [IW-1:0]          pos_r, pos_nxt;
  logic [UW-1:0]          len_r, len_nxt;
  status_t                st_r, st_nxt;
  logic [IW-1:0]          grant_r, grant_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [GRANT_W-1:0]     out_grant_r, out_grant_nxt;
  logic [OFFSET_W-1:0]    out_offset_r, out_offset_nxt;
  logic [USED_W-1:0]      out_used_r, out_used_nxt;
  logic [MAP_W-1:0]       out_map_r, out_map_nxt;

  logic [NUM_BLOCKS-1:0]  mask_init;
  logic [IDX_W-1:0]       grant_ext;
  logic [IDX_W+BB_W-1:0]  offset_prod;
  logic [CW-1:0]          len_ext;
  logic [CW-1:0]          idx_ext;
  logic                   fits;

  assign len_ext     = {1'b0, in_req.run_length};
  assign idx_ext     = {1'b0, in_req.block_index};
  assign grant_ext   = IDX_W'(grant_r);
  assign offset_prod = grant_ext * BB_L;
  assign fits        = ((occ_r & mask_r) == '0);

  always_comb begin
    for (int j = 0; j < NUM_BLOCKS; j++) begin
      mask_init[j] = (in_req.cmd == CMD_ALLOC) ? (j == 0) : (CW'(j) < len_ext);
    end
  end

  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    used_nxt       = used_r;
    mask_nxt       = mask_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    st_nxt         = st_r;
    grant_nxt      = grant_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_offset_nxt = out_offset_r;
    out_used_nxt   = out_used_r;
    out_map_nxt    = out_map_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          grant_nxt = '0;
          mask_nxt  = mask_init;
          pos_nxt   = '0;
          state_nxt = S_DONE;
          case (in_req.cmd)
            CMD_ALLOC: begin
              len_nxt   = UW'(1);
              state_nxt = S_SCAN;
            end
            CMD_RUN: begin
              if (len_ext == '0 || len_ext > NB_CMP) begin
                st_nxt = ST_BADLEN;
              end else begin
                len_nxt   = UW'(in_req.run_length);
                state_nxt = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (idx_ext >= NB_CMP || !occ_r[in_req.block_index[IW-1:0]]) begin
                st_nxt = ST_BADIDX;
              end else begin
                occ_nxt[in_req.block_index[IW-1:0]] = 1'b0;
                used_nxt = used_r - UW'(1);
                st_nxt   = ST_OK;
              end
            end
            default: begin
              st_nxt = ST_BADIDX;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (fits) begin
          occ_nxt   = occ_r | mask_r;
          used_nxt  = used_r + len_r;
          st_nxt    = ST_OK;
          grant_nxt = pos_r;
          state_nxt = S_DONE;
        end else if (mask_r[NUM_BLOCKS-1]) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          mask_nxt = {mask_r[NUM_BLOCKS-2:0], 1'b0};
          pos_nxt  = pos_r + IW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_grant_nxt  = GRANT_W'(grant_ext);
          out_offset_nxt = OFFSET_W'(offset_prod);
          out_used_nxt   = USED_W'(used_r);
          out_map_nxt    = MAP_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r       <= mask_nxt;
    pos_r        <= pos_nxt;
    len_r        <= len_nxt;
    st_r         <= st_nxt;
    grant_r      <= grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_offset_r <= out_offset_nxt;
    out_used_r   <= out_used_nxt;
    out_map_r    <= out_map_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_index = out_grant_r;
  assign out_rsp.byte_offset   = out_offset_r;
  assign out_rsp.used_blocks   = out_used_r;
  assign out_rsp.occupancy_map = out_map_r;

`include "bitmap_block_allocator_core_assert.svh"

  `BBA_ASSERT_IMPL(a_count_matches_map, 1'b1, $countones(occ_r) == used_r, "count and map disagree")
  `BBA_ASSERT_IMPL(a_scan_mask_live, state_r == S_SCAN, mask_r != '0, "scan mask shifted out")
  `BBA_ASSERT_NEXT(a_done_loads_output, state_r == S_DONE && state_nxt == S_IDLE, out_valid_r, "result not loaded")

endmodule

`default_nettype wire
